[rtl/core/slt_pkg.sv]
// Shared types and constants for the shell line tokenizer.
package slt_pkg;

    localparam logic [2:0] M_PLAIN = 3'd0;
    localparam logic [2:0] M_SQ    = 3'd1;
    localparam logic [2:0] M_DQ    = 3'd2;
    localparam logic [2:0] M_BS    = 3'd3;
    localparam logic [2:0] M_DQBS  = 3'd4;
    localparam logic [2:0] M_REDIR = 3'd5;

    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_ARG  = 2'd1;
    localparam logic [1:0] K_PATH = 2'd2;
    localparam logic [1:0] K_CMD  = 2'd3;

    localparam logic [1:0] T_INVALID = 2'd0;
    localparam logic [1:0] T_STDOUT  = 2'd1;
    localparam logic [1:0] T_STDERR  = 2'd2;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [2:0] mode;
        logic       word_open;
        logic       path_expected;
        logic [1:0] pending_target;
        logic       pending_append;
        logic [7:0] held_digit;
        logic       held_valid;
        logic       command_has_args;
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] target;
        logic       append;
        logic       last;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode: M_PLAIN, word_open: 1'b0, path_expected: 1'b0,
        pending_target: 2'd0, pending_append: 1'b0, held_digit: 8'd0,
        held_valid: 1'b0, command_has_args: 1'b0
    };

endpackage

[rtl/core/shell_line_tokenizer.sv]
// Top level of the shell line tokenizer: input register, lexer state and result burst.
// Path: an accepted byte waits in the input register, is stepped combinationally, and its
// events are loaded into the result register, which offers them on the single output port.
// Throughput: one byte per cycle while i_stall is low and each byte yields at most one
// event; a byte that yields more (up to four) holds the input until its last event is taken.
// Reset is synchronous and active low; it returns the lexer to plain mode and empties
// the input and result registers.
module shell_line_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_line_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_word_byte,
    output logic [1:0] o_redirect_target,
    output logic       o_redirect_appends,
    output logic       o_burst_last
);

    logic            r_in_valid;
    logic            n_in_valid;
    logic [7:0]      r_in_char;
    logic            r_in_last;
    slt_pkg::t_state r_state;
    slt_pkg::t_state step_state;
    slt_pkg::t_result [slt_pkg::MAX_RES-1:0] step_res;
    logic [2:0]      step_count;
    slt_pkg::t_result out_res;
    logic            q_free;
    logic            consume;
    logic            accept;

    assign consume = r_in_valid && q_free;
    assign o_stall = r_in_valid && !consume;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= slt_pkg::STATE_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (consume) begin
                r_state <= step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_in;
            r_in_last <= i_line_last;
        end
    end

    slt_step u_step (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_state (step_state),
        .o_res   (step_res),
        .o_count (step_count)
    );

    slt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_res   (step_res),
        .i_count (step_count),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_free  (q_free)
    );

    assign o_event_kind       = out_res.kind;
    assign o_word_byte        = out_res.data;
    assign o_redirect_target  = out_res.target;
    assign o_redirect_appends = out_res.append;
    assign o_burst_last       = out_res.last;

endmodule

[rtl/core/slt_step.sv]
// Combinational lexer step: next state and up to four events for one byte.
module slt_step (
    input  slt_pkg::t_state                      i_state,
    input  logic [7:0]                           i_char,
    input  logic                                 i_last,
    output slt_pkg::t_state                      o_state,
    output slt_pkg::t_result [slt_pkg::MAX_RES-1:0] o_res,
    output logic [2:0]                           o_count
);

    localparam logic [7:0] CH_ONE  = slt_pkg::CH_ZERO + 8'd1;
    localparam logic [7:0] CH_TWO  = slt_pkg::CH_ZERO + 8'd2;
    localparam logic [7:0] CH_NINE = slt_pkg::CH_ZERO + 8'd9;

    typedef struct packed {
        slt_pkg::t_state                         st;
        slt_pkg::t_result [slt_pkg::MAX_RES-1:0] res;
        logic [2:0]                              n;
    } t_ctx;

    function automatic t_ctx f_put(t_ctx x, logic [1:0] k, logic [7:0] b,
                                   logic [1:0] t, logic a);
        t_ctx y;
        y = x;
        if (y.n < 3'd4) begin
            y.res[y.n[1:0]] = '{kind: k, data: b, target: t, append: a, last: 1'b0};
            y.n = y.n + 3'd1;
        end
        return y;
    endfunction

    function automatic t_ctx f_emit(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = f_put(x, slt_pkg::K_BYTE, c, slt_pkg::T_INVALID, 1'b0);
        y.st.word_open = 1'b1;
        return y;
    endfunction

    function automatic t_ctx f_end_word(t_ctx x);
        t_ctx y;
        y = x;
        if (y.st.word_open) begin
            if (y.st.path_expected) begin
                y = f_put(y, slt_pkg::K_PATH, 8'd0, y.st.pending_target,
                          y.st.pending_append);
                y.st.path_expected = 1'b0;
            end else begin
                y = f_put(y, slt_pkg::K_ARG, 8'd0, slt_pkg::T_INVALID, 1'b0);
                y.st.command_has_args = 1'b1;
            end
            y.st.word_open = 1'b0;
        end
        return y;
    endfunction

    function automatic t_ctx f_start_redir(t_ctx x, logic [1:0] t);
        t_ctx y;
        y = x;
        y.st.path_expected  = 1'b1;
        y.st.pending_target = t;
        y.st.pending_append = 1'b0;
        y.st.mode           = slt_pkg::M_REDIR;
        return y;
    endfunction

    function automatic logic [1:0] f_digit_target(logic [7:0] d);
        logic [1:0] t;
        t = slt_pkg::T_INVALID;
        if (d == CH_ONE) begin
            t = slt_pkg::T_STDOUT;
        end else if (d == CH_TWO) begin
            t = slt_pkg::T_STDERR;
        end
        return t;
    endfunction

    function automatic t_ctx f_plain(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = x;
        y.st.mode = slt_pkg::M_PLAIN;
        if (c == slt_pkg::CH_SPACE) begin
            y = f_end_word(y);
        end else if (c == slt_pkg::CH_SQUOTE) begin
            y.st.mode = slt_pkg::M_SQ;
        end else if (c == slt_pkg::CH_DQUOTE) begin
            y.st.mode = slt_pkg::M_DQ;
        end else if (c == slt_pkg::CH_BSLASH) begin
            y.st.mode = slt_pkg::M_BS;
        end else if (c == slt_pkg::CH_GT) begin
            y = f_end_word(y);
            y = f_start_redir(y, slt_pkg::T_STDOUT);
        end else if (c == slt_pkg::CH_PIPE) begin
            y = f_end_word(y);
            y.st.path_expected = 1'b0;
            y = f_put(y, slt_pkg::K_CMD, 8'd0, slt_pkg::T_INVALID, 1'b0);
            y.st.command_has_args = 1'b0;
        end else if ((c inside {[slt_pkg::CH_ZERO:CH_NINE]}) && !y.st.word_open) begin
            y.st.held_digit = c;
            y.st.held_valid = 1'b1;
        end else begin
            y = f_emit(y, c);
        end
        return y;
    endfunction

    function automatic t_ctx f_process(t_ctx x, logic [7:0] c);
        t_ctx y;
        y = x;
        case (y.st.mode)
            slt_pkg::M_SQ: begin
                if (c == slt_pkg::CH_SQUOTE) begin
                    y.st.mode = slt_pkg::M_PLAIN;
                end else begin
                    y = f_emit(y, c);
                end
            end
            slt_pkg::M_DQ: begin
                if (c == slt_pkg::CH_DQUOTE) begin
                    y.st.mode = slt_pkg::M_PLAIN;
                end else if (c == slt_pkg::CH_BSLASH) begin
                    y.st.mode = slt_pkg::M_DQBS;
                end else begin
                    y = f_emit(y, c);
                end
            end
            slt_pkg::M_DQBS: begin
                if (c != slt_pkg::CH_DQUOTE && c != slt_pkg::CH_BSLASH) begin
                    y = f_emit(y, slt_pkg::CH_BSLASH);
                end
                y = f_emit(y, c);
                y.st.mode = slt_pkg::M_DQ;
            end
            slt_pkg::M_BS: begin
                y = f_emit(y, c);
                y.st.mode = slt_pkg::M_PLAIN;
            end
            slt_pkg::M_REDIR: begin
                if (c == slt_pkg::CH_GT) begin
                    y.st.pending_append = 1'b1;
                    y.st.mode = slt_pkg::M_PLAIN;
                end else begin
                    y = f_plain(y, c);
                end
            end
            default: begin
                y = f_plain(y, c);
            end
        endcase
        return y;
    endfunction

    t_ctx       x;
    logic       have_char;
    logic [7:0] digit;
    logic [2:0] last_idx;

    always_comb begin
        x.st      = i_state;
        x.res     = '0;
        x.n       = 3'd0;
        have_char = 1'b1;
        digit     = i_state.held_digit;
        last_idx  = 3'd0;
        if (x.st.held_valid) begin
            x.st.held_valid = 1'b0;
            x.st.held_digit = 8'd0;
            if (i_char == slt_pkg::CH_GT) begin
                x = f_start_redir(x, f_digit_target(digit));
                have_char = 1'b0;
            end else begin
                x = f_emit(x, digit);
            end
        end
        if (have_char) begin
            x = f_process(x, i_char);
        end
        if (i_last) begin
            if (x.st.held_valid) begin
                x = f_emit(x, x.st.held_digit);
            end
            x = f_end_word(x);
            if (x.st.command_has_args) begin
                x = f_put(x, slt_pkg::K_CMD, 8'd0, slt_pkg::T_INVALID, 1'b0);
            end
            x.st = slt_pkg::STATE_RESET;
        end
        if (x.n != 3'd0) begin
            last_idx = x.n - 3'd1;
            x.res[last_idx[1:0]].last = 1'b1;
        end
    end

    assign o_state = x.st;
    assign o_res   = x.res;
    assign o_count = x.n;

endmodule

[rtl/core/slt_outq.sv]
// Result burst register that hands out up to four events, one per cycle while i_stall is low.
module slt_outq (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  slt_pkg::t_result [slt_pkg::MAX_RES-1:0] i_res,
    input  logic [2:0]                              i_count,
    input  logic                                    i_stall,
    output logic                                    o_valid,
    output slt_pkg::t_result                        o_res,
    output logic                                    o_free
);

    slt_pkg::t_result [slt_pkg::MAX_RES-1:0] r_res;
    logic [2:0] r_left;
    logic [2:0] n_left;
    logic [1:0] r_head;
    logic [1:0] n_head;
    logic       pop;

    assign o_valid = (r_left != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_free  = (r_left == 3'd0) || ((r_left == 3'd1) && pop);
    assign o_res   = r_res[r_head];

    always_comb begin
        n_left = r_left;
        n_head = r_head;
        if (i_load) begin
            n_left = i_count;
            n_head = 2'd0;
        end else if (pop) begin
            n_left = r_left - 3'd1;
            n_head = r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_head <= 2'd0;
        end else begin
            r_left <= n_left;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/core/slt_checker.sv]
// Port-level assertions for the shell line tokenizer and their bind.
module slt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_event_kind,
    input logic [7:0] o_word_byte,
    input logic [1:0] o_redirect_target,
    input logic       o_redirect_appends,
    input logic       o_burst_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_kind) && $stable(o_word_byte)
            && $stable(o_redirect_target) && $stable(o_redirect_appends)
            && $stable(o_burst_last))
        else $error("Stalled output transaction changed.");

    a_marker_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != slt_pkg::K_BYTE |-> o_word_byte == 8'd0)
        else $error("Marker transaction carries a word byte.");

    a_target_only_on_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_kind != slt_pkg::K_PATH
            |-> o_redirect_target == slt_pkg::T_INVALID && !o_redirect_appends)
        else $error("Redirect fields set outside a path end.");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_redirect_target != 2'd3)
        else $error("Redirect target out of range.");

endmodule

bind shell_line_tokenizer slt_checker u_slt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_event_kind       (o_event_kind),
    .o_word_byte        (o_word_byte),
    .o_redirect_target  (o_redirect_target),
    .o_redirect_appends (o_redirect_appends),
    .o_burst_last       (o_burst_last)
);
